[rtl/core/stk_pkg.sv]
// shared types and constants for the lifo stack with membership search
// no dependencies; imported by stk_front, stk_back and the top level
`timescale 1ns / 1ps

package stk_pkg;

  // fixed field widths of the stream transactions
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned READ_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 7;
  localparam int unsigned OUT_W    = 48;

  // default sizing of the element store
  localparam int unsigned STACK_DEPTH_DEF   = 64;
  localparam int unsigned ELEMENT_WIDTH_DEF = 32;

  // command queue between front and back
  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_AW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int unsigned CQ_CW    = $clog2(CQ_DEPTH + 1);

  // opcodes on the input stream
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_SEARCH = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // decoded command kind, unknown opcodes become no-ops
  typedef enum logic [2:0] {
    K_PUSH,
    K_POP,
    K_PEEK,
    K_SEARCH,
    K_CLEAR,
    K_NOP
  } kind_e;

  // one queued command
  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

[rtl/core/stk_front.sv]
// front end: accepts input transactions, decodes the opcode, queues commands
// depends on stk_pkg
`timescale 1ns / 1ps

module stk_front
  import stk_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [VALUE_W-1:0]  s_axis_tdata,   // item_value[31:0]
  input  logic [OPCODE_W-1:0] s_axis_tuser,   // opcode[2:0]
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output cmd_t                cmd_o
);

  cmd_t             q_mem [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_CW-1:0] cnt_q, cnt_d;
  logic             push, pop;
  cmd_t             new_cmd;

  // opcode decode
  function automatic kind_e classify(input logic [OPCODE_W-1:0] op);
    kind_e k;
    unique case (op)
      OP_PUSH:   k = K_PUSH;
      OP_POP:    k = K_POP;
      OP_PEEK:   k = K_PEEK;
      OP_SEARCH: k = K_SEARCH;
      OP_CLEAR:  k = K_CLEAR;
      default:   k = K_NOP;
    endcase
    return k;
  endfunction

  function automatic logic [CQ_AW-1:0] ptr_inc(input logic [CQ_AW-1:0] p);
    logic [CQ_AW-1:0] n;
    if (p == CQ_AW'(CQ_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + CQ_AW'(1);
    end
    return n;
  endfunction

  // handshakes on both sides of the queue
  assign s_axis_tready = (cnt_q != CQ_CW'(CQ_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != '0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = q_mem[rd_ptr_q];

  always_comb begin
    new_cmd.kind  = classify(s_axis_tuser);
    new_cmd.value = s_axis_tdata;
  end

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
    end
    if (pop) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CQ_CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

[rtl/core/stk_back.sv]
// back end: element store, stack pointer, search sequencer and result register
// depends on stk_pkg; fed by stk_front
`timescale 1ns / 1ps

module stk_back
  import stk_pkg::*;
#(
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int unsigned ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  cmd_t               cmd_i,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OUT_W-1:0]   m_axis_tdata   // read_value[31:0], status[33:32],
                                            // found[34], fill_count[41:35], zero
);

  localparam int unsigned EW    = ELEMENT_WIDTH;
  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_RES
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               last_q, last_d;
  logic [EW-1:0]      key_q, key_d;
  logic               found_q, found_d;
  logic               is_pop_q, is_pop_d;
  logic               out_vld_q, out_vld_d;
  logic [READ_W-1:0]  out_rd_q, out_rd_d;
  status_e            out_st_q, out_st_d;
  logic               out_fnd_q, out_fnd_d;
  logic [FILL_W-1:0]  out_fill_q, out_fill_d;

  logic [EW-1:0]      mem_q [STACK_DEPTH];
  logic [EW-1:0]      rdat_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic [EW-1:0]      cmd_elem;

  logic               slot_free, full, empty;
  logic               res_en;
  logic [READ_W-1:0]  res_rd;
  status_e            res_st;
  logic               res_fnd;
  logic [CNT_W-1:0]   res_cnt;

  // width helpers
  function automatic logic [EW-1:0] to_elem(input logic [VALUE_W-1:0] v);
    logic [EW+VALUE_W-1:0] w;
    w = {{EW{1'b0}}, v};
    return w[EW-1:0];
  endfunction

  function automatic logic [READ_W-1:0] to_read(input logic [EW-1:0] d);
    logic [EW+READ_W-1:0] w;
    w = {{READ_W{1'b0}}, d};
    return w[READ_W-1:0];
  endfunction

  function automatic logic [FILL_W-1:0] to_fill(input logic [CNT_W-1:0] c);
    logic [CNT_W+FILL_W-1:0] w;
    w = {{FILL_W{1'b0}}, c};
    return w[FILL_W-1:0];
  endfunction

  assign cmd_elem  = to_elem(cmd_i.value);
  assign slot_free = !out_vld_q || m_axis_tready;
  assign full      = (count_q == CNT_W'(STACK_DEPTH));
  assign empty     = (count_q == '0);

  // command execution and next-state logic
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    last_d      = last_q;
    key_d       = key_q;
    found_d     = found_q;
    is_pop_d    = is_pop_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_rd_d    = out_rd_q;
    out_st_d    = out_st_q;
    out_fnd_d   = out_fnd_q;
    out_fill_d  = out_fill_q;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = count_q[AW-1:0];
    mem_re      = 1'b0;
    mem_ra      = idx_q[AW-1:0];
    res_en      = 1'b0;
    res_rd      = '0;
    res_st      = STAT_OK;
    res_fnd     = 1'b0;
    res_cnt     = count_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.kind)
            K_PUSH: begin
              res_en = 1'b1;
              if (full) begin
                res_st = STAT_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
                res_cnt = count_q + CNT_W'(1);
              end
            end
            K_POP, K_PEEK: begin
              if (empty) begin
                res_en = 1'b1;
                res_st = STAT_EMPTY;
              end else begin
                // read the top entry, result follows from the read register
                mem_re   = 1'b1;
                mem_ra   = AW'(count_q - CNT_W'(1));
                is_pop_d = (cmd_i.kind == K_POP);
                state_d  = S_READ;
              end
            end
            K_SEARCH: begin
              if (empty) begin
                res_en = 1'b1;
              end else begin
                // start the scan at the bottom of the stack
                mem_re  = 1'b1;
                mem_ra  = '0;
                idx_d   = CNT_W'(1);
                last_d  = (count_q == CNT_W'(1));
                key_d   = cmd_elem;
                found_d = 1'b0;
                state_d = S_SCAN;
              end
            end
            K_CLEAR: begin
              res_en  = 1'b1;
              count_d = '0;
              res_cnt = '0;
            end
            default: begin
              res_en = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (slot_free) begin
          res_en  = 1'b1;
          res_rd  = to_read(rdat_q);
          if (is_pop_q) begin
            count_d = count_q - CNT_W'(1);
            res_cnt = count_q - CNT_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        // compare the entry read last cycle, issue the next read
        if (rdat_q == key_q) begin
          found_d = 1'b1;
          state_d = S_RES;
        end else if (last_q) begin
          state_d = S_RES;
        end else begin
          mem_re = 1'b1;
          mem_ra = idx_q[AW-1:0];
          idx_d  = idx_q + CNT_W'(1);
          last_d = ((idx_q + CNT_W'(1)) == count_q);
        end
      end
      S_RES: begin
        if (slot_free) begin
          res_en  = 1'b1;
          res_fnd = found_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // load the output register
    if (res_en) begin
      out_vld_d  = 1'b1;
      out_rd_d   = res_rd;
      out_st_d   = res_st;
      out_fnd_d  = res_fnd;
      out_fill_d = to_fill(res_cnt);
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      idx_q      <= '0;
      last_q     <= 1'b0;
      key_q      <= '0;
      found_q    <= 1'b0;
      is_pop_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      out_rd_q   <= '0;
      out_st_q   <= STAT_OK;
      out_fnd_q  <= 1'b0;
      out_fill_q <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      last_q     <= last_d;
      key_q      <= key_d;
      found_q    <= found_d;
      is_pop_q   <= is_pop_d;
      out_vld_q  <= out_vld_d;
      out_rd_q   <= out_rd_d;
      out_st_q   <= out_st_d;
      out_fnd_q  <= out_fnd_d;
      out_fill_q <= out_fill_d;
    end
  end

  // element store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= cmd_elem;
    end
    if (mem_re) begin
      rdat_q <= mem_q[mem_ra];
    end
  end

  // output transaction
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OUT_W - READ_W - STATUS_W - 1 - FILL_W)'(0),
                          out_fill_q, out_fnd_q, out_st_q, out_rd_q};

`ifndef SYNTH
  // stack pointer never passes the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // no store write when full
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !full)
    else $error("store written while full");

  // a pending top read always has an element behind it
  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !empty)
    else $error("top read on empty stack");

  // scan never walks past the held elements
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= count_q) && (idx_q != '0))
    else $error("scan index out of range");

  // a command is taken only when its result can be placed or started
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> (state_q == S_IDLE) && slot_free)
    else $error("command taken while busy");
`endif

endmodule

[rtl/core/stack_with_membership_search_unit.sv]
// top level of the lifo stack with search; depends on stk_pkg, stk_front, stk_back
// push, clear and any empty pop, peek or search finish directly from idle; other pops and
// peeks go through a registered store read, a search reads one store entry per step from
// the bottom and stops at a match or the last entry; one push or clear per cycle while the
// output is not stalled, no new command is taken while a read or search is pending
// reset clears the stack count, the command queue and the result register, not the store
`timescale 1ns / 1ps

module stack_with_membership_search_unit
  import stk_pkg::*;
#(
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int unsigned ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [VALUE_W-1:0]  s_axis_tdata,   // item_value[31:0]
  input  logic [OPCODE_W-1:0] s_axis_tuser,   // opcode[2:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata    // read_value[31:0], status[33:32],
                                              // found[34], fill_count[41:35], zero
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // decode and queue
  stk_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  // execute against the store
  stk_back #(
    .STACK_DEPTH   (STACK_DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
